// File: rtl/tprq_pkg.sv
// package for the two-level priority request queue
// holds default sizes, request codes and status codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tprq_pkg;

    // default sizes
    localparam int DEPTH_DEF    = 64;
    localparam int ID_WIDTH_DEF = 16;

    // field widths fixed by the interface
    localparam int REQ_W    = 2;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HANDLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // priority value that selects the high queue
    localparam logic [PRIO_W-1:0] PRIO_HIGH = 8'd1;

    // where a pending result takes its head fields from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_HIGH = 2'd1,
        SRC_LOW  = 2'd2
    } t_src;

    // control info handed from the accept cycle to the result cycle
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_src                src;
    } t_pend;

endpackage

`default_nettype wire

// File: rtl/two_level_priority_request_queue.sv
// two-level strict priority request queue, top level
// keeps a high and a low circular fifo in two synchronous memories
// depends on tprq_pkg
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one request transaction:
//   submit, handle (remove next) or peek next. output channel
//   (o_out_valid / i_out_ready) returns exactly one result transaction per
//   request: status, head id, head priority and a from-high flag.
//   the head is read from the queue memory in the accept cycle and the
//   registered read data is loaded into the output register in the next
//   cycle. a new request is not taken while the previous one is pending;
//   it can be taken in the same cycle the previous result leaves.
//   reset: synchronous, active low; both queues empty, no result pending.
//   queue memories are not cleared; the counts decide whether read data is used.
//   receiver stall: the result holds in the output register and no new
//   request is accepted until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module two_level_priority_request_queue #(
    parameter int DEPTH    = tprq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = tprq_pkg::ID_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tprq_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [ID_WIDTH-1:0]           i_request_id,
    input  wire logic [tprq_pkg::PRIO_W-1:0]   i_priority_level,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [tprq_pkg::STATUS_W-1:0]      o_status,
    output logic [ID_WIDTH-1:0]                o_head_id,
    output logic [tprq_pkg::PRIO_W-1:0]        o_head_priority,
    output logic                               o_from_high
);
    import tprq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam int LW = ID_WIDTH + PRIO_W;

    // queue memories
    logic [ID_WIDTH-1:0] high_mem [DEPTH];
    logic [LW-1:0]       low_mem  [DEPTH];

    // pointers and counts
    logic [AW-1:0] r_hi_head, r_hi_tail, r_lo_head, r_lo_tail;
    logic [AW-1:0] n_hi_head, n_hi_tail, n_lo_head, n_lo_tail;
    logic [CW-1:0] r_hi_count, r_lo_count, n_hi_count, n_lo_count;

    // pipeline control
    logic  r_pend_valid;
    t_pend r_pend, n_pend;
    logic  r_out_valid;

    // registered read data
    logic [ID_WIDTH-1:0] r_hi_rd;
    logic [LW-1:0]       r_lo_rd;

    logic w_in_acc, w_out_acc;
    logic w_hi_we, w_lo_we, w_rd_en;

    assign w_out_acc  = r_out_valid && i_out_ready;
    assign o_in_ready = !r_pend_valid && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // request decode and pointer updates
    always_comb begin
        n_hi_head  = r_hi_head;
        n_hi_tail  = r_hi_tail;
        n_lo_head  = r_lo_head;
        n_lo_tail  = r_lo_tail;
        n_hi_count = r_hi_count;
        n_lo_count = r_lo_count;
        n_pend     = '{status: ST_OK, src: SRC_NONE};
        w_hi_we    = 1'b0;
        w_lo_we    = 1'b0;
        w_rd_en    = 1'b0;
        if (w_in_acc) begin
            case (i_req_type)
                REQ_SUBMIT: begin
                    if (i_priority_level == PRIO_HIGH) begin
                        if (r_hi_count == FULL_CNT) begin
                            n_pend.status = ST_FULL;
                        end else begin
                            w_hi_we    = 1'b1;
                            n_hi_tail  = next_slot(r_hi_tail);
                            n_hi_count = r_hi_count + CW'(1);
                        end
                    end else begin
                        if (r_lo_count == FULL_CNT) begin
                            n_pend.status = ST_FULL;
                        end else begin
                            w_lo_we    = 1'b1;
                            n_lo_tail  = next_slot(r_lo_tail);
                            n_lo_count = r_lo_count + CW'(1);
                        end
                    end
                end
                REQ_HANDLE, REQ_PEEK: begin
                    w_rd_en = 1'b1;
                    if (r_hi_count != '0) begin
                        n_pend.src = SRC_HIGH;
                        if (i_req_type == REQ_HANDLE) begin
                            n_hi_head  = next_slot(r_hi_head);
                            n_hi_count = r_hi_count - CW'(1);
                        end
                    end else if (r_lo_count != '0) begin
                        n_pend.src = SRC_LOW;
                        if (i_req_type == REQ_HANDLE) begin
                            n_lo_head  = next_slot(r_lo_head);
                            n_lo_count = r_lo_count - CW'(1);
                        end
                    end else begin
                        n_pend.status = ST_EMPTY;
                    end
                end
                default: begin
                    n_pend = '{status: ST_OK, src: SRC_NONE};
                end
            endcase
        end
    end

    // memory write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (w_hi_we) begin
            high_mem[r_hi_tail] <= i_request_id;
        end
        if (w_lo_we) begin
            low_mem[r_lo_tail] <= {i_request_id, i_priority_level};
        end
        if (w_rd_en) begin
            r_hi_rd <= high_mem[r_hi_head];
            r_lo_rd <= low_mem[r_lo_head];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_head    <= '0;
            r_hi_tail    <= '0;
            r_lo_head    <= '0;
            r_lo_tail    <= '0;
            r_hi_count   <= '0;
            r_lo_count   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hi_head    <= n_hi_head;
            r_hi_tail    <= n_hi_tail;
            r_lo_head    <= n_lo_head;
            r_lo_tail    <= n_lo_tail;
            r_hi_count   <= n_hi_count;
            r_lo_count   <= n_lo_count;
            r_pend_valid <= w_in_acc;
            if (r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending transaction info
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend <= n_pend;
        end
    end

    // output register load from read data
    always_ff @(posedge i_clk) begin
        if (r_pend_valid) begin
            o_status <= r_pend.status;
            case (r_pend.src)
                SRC_HIGH: begin
                    o_head_id       <= r_hi_rd;
                    o_head_priority <= PRIO_HIGH;
                    o_from_high     <= 1'b1;
                end
                SRC_LOW: begin
                    o_head_id       <= r_lo_rd[LW-1:PRIO_W];
                    o_head_priority <= r_lo_rd[PRIO_W-1:0];
                    o_from_high     <= 1'b0;
                end
                default: begin
                    o_head_id       <= '0;
                    o_head_priority <= '0;
                    o_from_high     <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    a_hi_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi_count <= FULL_CNT)
        else $error("high count above depth");
    a_lo_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_count <= FULL_CNT)
        else $error("low count above depth");
    a_pend_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |=> r_out_valid)
        else $error("pending result not loaded");
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> ($stable(r_hi_count) && $stable(r_lo_count)))
        else $error("count moved without a transaction");

endmodule

`default_nettype wire
